// ----- hdl/apsp_pkg.sv -----
`default_nettype none
package apsp_pkg;

  // Operation codes carried by the opcode field.
  localparam logic [1:0] OP_ADD     = 2'd0;
  localparam logic [1:0] OP_COMPUTE = 2'd1;
  localparam logic [1:0] OP_QUERY   = 2'd2;
  localparam logic [1:0] OP_CLEAR   = 2'd3;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NO_PATH  = 3'd1,
    ST_FULL     = 3'd2,
    ST_NEG_LOOP = 3'd3,
    ST_BAD_NODE = 3'd4,
    ST_NOT_DONE = 3'd5
  } status_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_QWAIT,
    S_VINIT,
    S_EDGE,
    S_EREAD,
    S_RELAX,
    S_SRC,
    S_SRD,
    S_SWR
  } state_t;

  // Range of the distance field.
  localparam int DIST_MAX = 2097151;
  localparam int DIST_MIN = -2097152;

endpackage
`default_nettype wire

// ----- hdl/apsp_ram.sv -----
`default_nettype none
module apsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                                 clk,
  input  wire logic                                 wr_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                     wr_data,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr_a,
  output logic      [WIDTH-1:0]                     rd_data_a,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr_b,
  output logic      [WIDTH-1:0]                     rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and two registered read ports.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule
`default_nettype wire

// ----- hdl/all_pairs_shortest_path_core.sv -----
`default_nettype none
// Add, clear and rejected query beats give their result in the cycle after acceptance, and a
// query of computed results passes through S_QWAIT for the registered pair read; the
// receiver cannot stall. Compute zeroes n node distances, runs Pv passes of the shared
// relaxation unit over E stored edges, then per source P passes and a sweep writing n
// pairs (Pv, P at most n); a negative cycle ends it after Pv passes. Busy is high meanwhile.
// Synchronous reset clears the edge count and result flags and sets node_count to 64.
module all_pairs_shortest_path_core #(
  parameter int MAX_NODES   = 64,
  parameter int MAX_EDGES   = 1024,
  parameter int WEIGHT_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         opcode,
  input  wire logic [6:0]         source_node,
  input  wire logic [6:0]         target_node,
  input  wire logic signed [15:0] edge_weight_in,
  input  wire logic               node_count_wr,
  input  wire logic [6:0]         node_count,
  output logic                    done,
  output logic signed [21:0]      distance,
  output logic [2:0]              status
);

  localparam int NW     = $clog2(MAX_NODES);
  localparam int W      = WEIGHT_BITS;
  localparam int EAW    = MAX_EDGES > 1 ? $clog2(MAX_EDGES) : 1;
  localparam int ECW    = $clog2(MAX_EDGES + 1);
  localparam int DW_RAW = W + $clog2(MAX_EDGES) + NW + 2;
  localparam int DW     = DW_RAW < 24 ? 24 : DW_RAW;
  localparam int EWD    = 2 * NW + W;
  localparam int PAW    = 2 * NW;
  localparam int CW     = NW + 1;
  localparam longint WHI = (longint'(1) <<< (W - 1)) - 1;
  localparam longint WLO = -WHI - 1;
  localparam logic signed [DW-1:0] DMAX = DW'(apsp_pkg::DIST_MAX);
  localparam logic signed [DW-1:0] DMIN = DW'(apsp_pkg::DIST_MIN);
  localparam logic [6:0] NC_RESET = 7'(MAX_NODES < 64 ? MAX_NODES : 64);

  apsp_pkg::state_t  state, state_next;
  apsp_pkg::status_t result_status;

  logic [6:0]           nodes_used;
  logic [ECW-1:0]       edges_stored;
  logic                 results_valid, cycle_found;
  logic                 virt;
  logic [NW-1:0]        src_idx;
  logic [CW-1:0]        pass, sweep;
  logic [ECW-1:0]       edge_idx;
  logic                 changed;
  logic [MAX_NODES-1:0] seen;

  logic [8:0]          nc9;
  logic                acc, nodes_ok, full;
  logic [7:0]          s0, t0;
  longint              win;
  logic signed [W-1:0] w_sat;
  logic [6:0]          nc_clamped;

  logic           e_we;
  logic [EWD-1:0] e_q;
  logic [NW-1:0]  e_from, e_to;
  logic signed [W-1:0] e_cost;

  logic          d_we;
  logic [NW-1:0] d_wa, d_ra;
  logic signed [DW-1:0] d_wd, d_qa, d_qb, cand, d_clip;
  logic          live, upd;

  logic           p_we;
  logic [22:0]    p_wd, p_q;

  logic pass_end, last_pass, sweep_last, src_last;

  assign nc9  = {2'b0, nodes_used};
  assign acc  = start && !busy;
  assign busy = (state != apsp_pkg::S_IDLE);
  assign status = result_status;

  // Node checks of the incoming beat.
  assign s0 = {1'b0, source_node} - 8'd1;
  assign t0 = {1'b0, target_node} - 8'd1;
  assign nodes_ok = (source_node != 7'd0) && (source_node <= nodes_used) &&
                    (target_node != 7'd0) && (target_node <= nodes_used);
  assign full = ({1'b0, edges_stored} >= (ECW + 1)'(MAX_EDGES));

  // Weight saturation to the stored width.
  always_comb begin
    win = longint'(edge_weight_in);
    if (win > WHI) begin
      w_sat = W'(WHI);
    end else if (win < WLO) begin
      w_sat = W'(WLO);
    end else begin
      w_sat = W'(win);
    end
  end

  // Clamp of a written node count.
  always_comb begin
    if (node_count == 7'd0) begin
      nc_clamped = 7'd1;
    end else if ({2'b0, node_count} > 9'(MAX_NODES)) begin
      nc_clamped = 7'(MAX_NODES);
    end else begin
      nc_clamped = node_count;
    end
  end

  // Edge table: target, source and cost of each stored edge.
  assign e_we = acc && (opcode == apsp_pkg::OP_ADD) && nodes_ok && !full;
  assign e_cost = $signed(e_q[W-1:0]);
  assign e_from = e_q[W+NW-1:W];
  assign e_to   = e_q[W+2*NW-1:W+NW];

  apsp_ram #(.WIDTH(EWD), .DEPTH(MAX_EDGES)) u_edges (
    .clk       (clk),
    .wr_en     (e_we),
    .wr_addr   (edges_stored[EAW-1:0]),
    .wr_data   ({t0[NW-1:0], s0[NW-1:0], w_sat}),
    .rd_addr_a (edge_idx[EAW-1:0]),
    .rd_data_a (e_q),
    .rd_addr_b (edge_idx[EAW-1:0]),
    .rd_data_b ()
  );

  // Shared relaxation unit: one add and one compare per edge.
  assign live = (9'(e_from) < nc9) && (9'(e_to) < nc9);
  assign cand = d_qa + {{(DW - W){e_cost[W-1]}}, e_cost};
  assign upd  = live && seen[e_from] && (!seen[e_to] || (cand < d_qb));

  // Working distance store.
  always_comb begin
    d_we = 1'b0;
    d_wa = e_to;
    d_wd = cand;
    unique case (state)
      apsp_pkg::S_VINIT: begin
        d_we = 1'b1;
        d_wa = sweep[NW-1:0];
        d_wd = '0;
      end
      apsp_pkg::S_SRC: begin
        d_we = 1'b1;
        d_wa = src_idx;
        d_wd = '0;
      end
      apsp_pkg::S_RELAX: begin
        d_we = upd;
      end
      default: begin
      end
    endcase
  end
  assign d_ra = (state == apsp_pkg::S_SRD) ? sweep[NW-1:0] : e_from;

  apsp_ram #(.WIDTH(DW), .DEPTH(MAX_NODES)) u_dist (
    .clk       (clk),
    .wr_en     (d_we),
    .wr_addr   (d_wa),
    .wr_data   (d_wd),
    .rd_addr_a (d_ra),
    .rd_data_a (d_qa),
    .rd_addr_b (e_to),
    .rd_data_b (d_qb)
  );

  // Pair table: reachable bit over the saturated distance.
  always_comb begin
    if (d_qa > DMAX) begin
      d_clip = DMAX;
    end else if (d_qa < DMIN) begin
      d_clip = DMIN;
    end else begin
      d_clip = d_qa;
    end
  end
  assign p_we = (state == apsp_pkg::S_SWR);
  assign p_wd = {seen[sweep[NW-1:0]], d_clip[21:0]};

  apsp_ram #(.WIDTH(23), .DEPTH(1 << PAW)) u_pairs (
    .clk       (clk),
    .wr_en     (p_we),
    .wr_addr   ({src_idx, sweep[NW-1:0]}),
    .wr_data   (p_wd),
    .rd_addr_a ({s0[NW-1:0], t0[NW-1:0]}),
    .rd_data_a (p_q),
    .rd_addr_b ({s0[NW-1:0], t0[NW-1:0]}),
    .rd_data_b ()
  );

  assign pass_end   = (edge_idx == edges_stored);
  assign last_pass  = (9'(pass) + 9'd1 == nc9);
  assign sweep_last = (9'(sweep) + 9'd1 == nc9);
  assign src_last   = (9'(src_idx) + 9'd1 == nc9);

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= apsp_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      apsp_pkg::S_IDLE: begin
        if (acc && opcode == apsp_pkg::OP_COMPUTE) begin
          state_next = apsp_pkg::S_VINIT;
        end else if (acc && opcode == apsp_pkg::OP_QUERY && nodes_ok && results_valid) begin
          state_next = apsp_pkg::S_QWAIT;
        end
      end
      apsp_pkg::S_QWAIT: state_next = apsp_pkg::S_IDLE;
      apsp_pkg::S_VINIT: begin
        if (sweep_last) begin
          state_next = apsp_pkg::S_EDGE;
        end
      end
      apsp_pkg::S_EDGE: begin
        if (!pass_end) begin
          state_next = apsp_pkg::S_EREAD;
        end else if (!changed) begin
          state_next = virt ? apsp_pkg::S_SRC : apsp_pkg::S_SRD;
        end else if (last_pass) begin
          state_next = virt ? apsp_pkg::S_IDLE : apsp_pkg::S_SRD;
        end
      end
      apsp_pkg::S_EREAD: state_next = apsp_pkg::S_RELAX;
      apsp_pkg::S_RELAX: state_next = apsp_pkg::S_EDGE;
      apsp_pkg::S_SRC:   state_next = apsp_pkg::S_EDGE;
      apsp_pkg::S_SRD:   state_next = apsp_pkg::S_SWR;
      apsp_pkg::S_SWR: begin
        if (!sweep_last) begin
          state_next = apsp_pkg::S_SRD;
        end else begin
          state_next = src_last ? apsp_pkg::S_IDLE : apsp_pkg::S_SRC;
        end
      end
      default: state_next = apsp_pkg::S_IDLE;
    endcase
  end

  // Flags, counters and the result beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      nodes_used    <= NC_RESET;
      edges_stored  <= '0;
      results_valid <= 1'b0;
      cycle_found   <= 1'b0;
      done          <= 1'b0;
    end else begin
      done <= 1'b0;
      if (node_count_wr) begin
        nodes_used    <= nc_clamped;
        results_valid <= 1'b0;
        cycle_found   <= 1'b0;
      end
      case (state)
        apsp_pkg::S_IDLE: begin
          if (acc) begin
            distance <= '0;
            case (opcode)
              apsp_pkg::OP_ADD: begin
                done <= 1'b1;
                if (!nodes_ok) begin
                  result_status <= apsp_pkg::ST_BAD_NODE;
                end else if (full) begin
                  result_status <= apsp_pkg::ST_FULL;
                end else begin
                  result_status <= apsp_pkg::ST_OK;
                  edges_stored  <= edges_stored + 1'b1;
                  results_valid <= 1'b0;
                  cycle_found   <= 1'b0;
                end
              end
              apsp_pkg::OP_CLEAR: begin
                done          <= 1'b1;
                result_status <= apsp_pkg::ST_OK;
                edges_stored  <= '0;
                results_valid <= 1'b0;
                cycle_found   <= 1'b0;
              end
              apsp_pkg::OP_QUERY: begin
                if (!nodes_ok) begin
                  done          <= 1'b1;
                  result_status <= apsp_pkg::ST_BAD_NODE;
                end else if (!results_valid) begin
                  done          <= 1'b1;
                  result_status <= cycle_found ? apsp_pkg::ST_NEG_LOOP : apsp_pkg::ST_NOT_DONE;
                end
              end
              default: begin
                sweep    <= '0;
                seen     <= '1;
                virt     <= 1'b1;
                pass     <= '0;
                edge_idx <= '0;
                changed  <= 1'b0;
              end
            endcase
          end
        end
        apsp_pkg::S_QWAIT: begin
          done          <= 1'b1;
          result_status <= p_q[22] ? apsp_pkg::ST_OK : apsp_pkg::ST_NO_PATH;
          distance      <= p_q[22] ? $signed(p_q[21:0]) : 22'sd0;
        end
        apsp_pkg::S_VINIT: begin
          sweep <= sweep + 1'b1;
        end
        apsp_pkg::S_EDGE: begin
          if (pass_end) begin
            pass     <= pass + 1'b1;
            edge_idx <= '0;
            changed  <= 1'b0;
            if (!changed || last_pass) begin
              if (virt && !changed) begin
                virt    <= 1'b0;
                src_idx <= '0;
              end else if (virt) begin
                done          <= 1'b1;
                distance      <= '0;
                result_status <= apsp_pkg::ST_NEG_LOOP;
                cycle_found   <= 1'b1;
                results_valid <= 1'b0;
              end else begin
                sweep <= '0;
              end
            end
          end
        end
        apsp_pkg::S_RELAX: begin
          if (upd) begin
            seen[e_to] <= 1'b1;
            changed    <= 1'b1;
          end
          edge_idx <= edge_idx + 1'b1;
        end
        apsp_pkg::S_SRC: begin
          seen     <= {{(MAX_NODES - 1){1'b0}}, 1'b1} << src_idx;
          pass     <= '0;
          edge_idx <= '0;
          changed  <= 1'b0;
        end
        apsp_pkg::S_SWR: begin
          sweep <= sweep_last ? '0 : sweep + 1'b1;
          if (sweep_last) begin
            if (src_last) begin
              done          <= 1'b1;
              distance      <= '0;
              result_status <= apsp_pkg::ST_OK;
              results_valid <= 1'b1;
              cycle_found   <= 1'b0;
            end else begin
              src_idx <= src_idx + 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // A result beat never overlaps work in progress.
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result beat while busy");

  // Edge table updates and clears answer in the next cycle.
  a_add_quick: assert property (@(posedge clk) disable iff (rst)
    (acc && (opcode == apsp_pkg::OP_ADD || opcode == apsp_pkg::OP_CLEAR)) |=> done)
    else $error("edge beat without result");

  // The edge count stays within the table.
  a_edges_bound: assert property (@(posedge clk) disable iff (rst)
    {1'b0, edges_stored} <= (ECW + 1)'(MAX_EDGES))
    else $error("edge count beyond table");

  // Distance is zero unless the status is ok.
  a_dist_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result_status != apsp_pkg::ST_OK) |-> (distance == 22'sd0))
    else $error("distance set on failed beat");

  // Both result flags are never set together.
  a_flags: assert property (@(posedge clk) disable iff (rst)
    !(results_valid && cycle_found))
    else $error("valid results with a negative cycle");

endmodule
`default_nettype wire

// ----- tb/sv/all_pairs_shortest_path_core_tb.sv -----
`default_nettype none
module all_pairs_shortest_path_core_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODES_MAX = 64;
  localparam int EDGE_SLOTS = 1024;
  localparam int ITEM_TARGET = 1800;
  localparam int IDLE_LIMIT = 50000000;

  typedef enum {K_BEAT, K_CFG, K_PAUSE} stim_kind_t;

  typedef struct {
    stim_kind_t         kind;
    logic [1:0]         op;
    logic [6:0]         src;
    logic [6:0]         dst;
    logic [15:0]        weight;
    int                 gap;
    bit                 fixed;
    apsp_pkg::status_t  fixed_status;
    logic signed [21:0] fixed_dist;
  } stim_t;

  typedef struct {
    logic signed [21:0] path_len;
    apsp_pkg::status_t  st;
  } path_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [1:0] opcode = apsp_pkg::OP_ADD;
  logic [6:0] source_node = '0;
  logic [6:0] target_node = '0;
  logic signed [15:0] edge_weight_in = '0;
  logic node_count_wr = 1'b0;
  logic [6:0] node_count = 7'd64;
  logic busy;
  logic done;
  logic signed [21:0] distance;
  logic [2:0] status;

  stim_t stim_q[$];
  path_result_t pending_paths[$];
  int fail_count = 0;
  int idle_cycles = 0;

  // Shadow copy of the edge table, the node count and the distance table.
  logic [5:0] sh_from[EDGE_SLOTS];
  logic [5:0] sh_to[EDGE_SLOTS];
  logic signed [15:0] sh_cost[EDGE_SLOTS];
  int sh_edges;
  int sh_nodes;
  bit sh_valid;
  bit sh_neg;
  longint sh_dist[NODES_MAX][NODES_MAX];
  bit sh_reach[NODES_MAX][NODES_MAX];

  all_pairs_shortest_path_core u_dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .opcode         (opcode),
    .source_node    (source_node),
    .target_node    (target_node),
    .edge_weight_in (edge_weight_in),
    .node_count_wr  (node_count_wr),
    .node_count     (node_count),
    .done           (done),
    .distance       (distance),
    .status         (status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Applies a node count write to the shadow state.
  function automatic void shadow_set_nodes(logic [6:0] v);
    int n;
    n = int'(v);
    if (n == 0) n = 1;
    if (n > NODES_MAX) n = NODES_MAX;
    sh_nodes = n;
    sh_valid = 0;
    sh_neg = 0;
  endfunction

  // Floyd-Warshall over the live edges; returns 1 when a negative cycle exists.
  function automatic bit solve_all_pairs();
    int n;
    longint c;
    bit neg;
    n = sh_nodes;
    neg = 0;
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++) begin
        sh_reach[i][j] = (i == j);
        sh_dist[i][j] = 0;
      end
    for (int e = 0; e < sh_edges; e++) begin
      if (sh_from[e] < n && sh_to[e] < n) begin
        if (!sh_reach[sh_from[e]][sh_to[e]] || sh_cost[e] < sh_dist[sh_from[e]][sh_to[e]]) begin
          sh_reach[sh_from[e]][sh_to[e]] = 1;
          sh_dist[sh_from[e]][sh_to[e]] = sh_cost[e];
        end
      end
    end
    for (int k = 0; k < n; k++)
      for (int i = 0; i < n; i++)
        if (sh_reach[i][k])
          for (int j = 0; j < n; j++)
            if (sh_reach[k][j]) begin
              c = sh_dist[i][k] + sh_dist[k][j];
              if (!sh_reach[i][j] || c < sh_dist[i][j]) begin
                sh_reach[i][j] = 1;
                sh_dist[i][j] = c;
              end
            end
    for (int i = 0; i < n; i++)
      if (sh_dist[i][i] < 0) neg = 1;
    return neg;
  endfunction

  // Works out the result of one accepted beat and updates the shadow state.
  function automatic path_result_t predict_path(logic [1:0] op, logic [6:0] s,
                                                logic [6:0] t, logic signed [15:0] w);
    path_result_t r;
    bit nodes_ok;
    longint d;
    r.path_len = '0;
    r.st = apsp_pkg::ST_OK;
    nodes_ok = s >= 1 && s <= sh_nodes && t >= 1 && t <= sh_nodes;
    case (op)
      apsp_pkg::OP_ADD: begin
        if (!nodes_ok) r.st = apsp_pkg::ST_BAD_NODE;
        else if (sh_edges >= EDGE_SLOTS) r.st = apsp_pkg::ST_FULL;
        else begin
          sh_from[sh_edges] = 6'(s - 1);
          sh_to[sh_edges] = 6'(t - 1);
          sh_cost[sh_edges] = w;
          sh_edges++;
          sh_valid = 0;
          sh_neg = 0;
        end
      end
      apsp_pkg::OP_COMPUTE: begin
        if (solve_all_pairs()) begin
          sh_neg = 1;
          sh_valid = 0;
          r.st = apsp_pkg::ST_NEG_LOOP;
        end else begin
          sh_neg = 0;
          sh_valid = 1;
        end
      end
      apsp_pkg::OP_QUERY: begin
        if (!nodes_ok) r.st = apsp_pkg::ST_BAD_NODE;
        else if (!sh_valid) r.st = sh_neg ? apsp_pkg::ST_NEG_LOOP : apsp_pkg::ST_NOT_DONE;
        else if (!sh_reach[s - 1][t - 1]) r.st = apsp_pkg::ST_NO_PATH;
        else begin
          d = sh_dist[s - 1][t - 1];
          if (d > apsp_pkg::DIST_MAX) d = apsp_pkg::DIST_MAX;
          if (d < apsp_pkg::DIST_MIN) d = apsp_pkg::DIST_MIN;
          r.path_len = 22'(d);
        end
      end
      default: begin
        sh_edges = 0;
        sh_valid = 0;
        sh_neg = 0;
      end
    endcase
    return r;
  endfunction

  function automatic void push_beat(logic [1:0] op, int s, int t, int w, int gap,
                                    bit fixed = 0,
                                    apsp_pkg::status_t st = apsp_pkg::ST_OK, int d = 0);
    stim_t x;
    x.kind = K_BEAT;
    x.op = op;
    x.src = 7'(s);
    x.dst = 7'(t);
    x.weight = 16'(w);
    x.gap = gap;
    x.fixed = fixed;
    x.fixed_status = st;
    x.fixed_dist = 22'(d);
    stim_q = {stim_q, x};
  endfunction

  function automatic void push_marker(stim_kind_t k, int v);
    stim_t x;
    x.kind = k;
    x.op = apsp_pkg::OP_ADD;
    x.src = 7'(v);
    x.dst = '0;
    x.weight = '0;
    x.gap = 0;
    x.fixed = 0;
    x.fixed_status = apsp_pkg::ST_OK;
    x.fixed_dist = '0;
    stim_q = {stim_q, x};
  endfunction

  // Directed rows: extremes, bad nodes, negative cycles and the smallest node count.
  function automatic void build_directed();
    push_beat(apsp_pkg::OP_QUERY, 1, 1, 0, 0, 1, apsp_pkg::ST_NOT_DONE, 0);
    push_beat(apsp_pkg::OP_ADD, 0, 1, 5, 3, 1, apsp_pkg::ST_BAD_NODE, 0);
    push_beat(apsp_pkg::OP_ADD, 1, 65, 5, 0, 1, apsp_pkg::ST_BAD_NODE, 0);
    push_beat(apsp_pkg::OP_QUERY, 127, 2, 0, 1, 1, apsp_pkg::ST_BAD_NODE, 0);
    push_beat(apsp_pkg::OP_ADD, 1, 2, 32767, 0, 1, apsp_pkg::ST_OK, 0);
    push_beat(apsp_pkg::OP_ADD, 2, 64, -32768, 2, 1, apsp_pkg::ST_OK, 0);
    push_beat(apsp_pkg::OP_COMPUTE, 0, 0, 0, 0, 1, apsp_pkg::ST_OK, 0);
    push_beat(apsp_pkg::OP_QUERY, 1, 64, 0, 0);
    push_beat(apsp_pkg::OP_QUERY, 64, 1, 0, 4, 1, apsp_pkg::ST_NO_PATH, 0);
    push_beat(apsp_pkg::OP_QUERY, 64, 64, 0, 0, 1, apsp_pkg::ST_OK, 0);
    push_beat(apsp_pkg::OP_ADD, 64, 1, -5, 0, 1, apsp_pkg::ST_OK, 0);
    push_beat(apsp_pkg::OP_QUERY, 1, 2, 0, 0, 1, apsp_pkg::ST_NOT_DONE, 0);
    push_beat(apsp_pkg::OP_COMPUTE, 0, 0, 0, 0, 1, apsp_pkg::ST_NEG_LOOP, 0);
    push_beat(apsp_pkg::OP_QUERY, 1, 2, 0, 0, 1, apsp_pkg::ST_NEG_LOOP, 0);
    push_beat(apsp_pkg::OP_CLEAR, 0, 0, 0, 0, 1, apsp_pkg::ST_OK, 0);
    push_beat(apsp_pkg::OP_QUERY, 1, 2, 0, 0, 1, apsp_pkg::ST_NOT_DONE, 0);
    push_beat(apsp_pkg::OP_ADD, 7, 7, -1, 0, 1, apsp_pkg::ST_OK, 0);
    push_beat(apsp_pkg::OP_COMPUTE, 0, 0, 0, 0, 1, apsp_pkg::ST_NEG_LOOP, 0);
    push_beat(apsp_pkg::OP_CLEAR, 0, 0, 0, 0, 1, apsp_pkg::ST_OK, 0);
    push_marker(K_CFG, 0);
    push_beat(apsp_pkg::OP_ADD, 1, 1, 9, 0, 1, apsp_pkg::ST_OK, 0);
    push_beat(apsp_pkg::OP_ADD, 1, 2, 9, 0, 1, apsp_pkg::ST_BAD_NODE, 0);
    push_beat(apsp_pkg::OP_COMPUTE, 0, 0, 0, 0, 1, apsp_pkg::ST_OK, 0);
    push_beat(apsp_pkg::OP_QUERY, 1, 1, 0, 0, 1, apsp_pkg::ST_OK, 0);
    push_marker(K_PAUSE, 0);
  endfunction

  function automatic int pick_weight();
    case ($urandom_range(0, 5))
      0: return int'($urandom_range(0, 65535)) - 32768;
      1: return $urandom_range(0, 1) ? 32767 : -32768;
      default: return int'($urandom_range(0, 300)) - 40;
    endcase
  endfunction

  // Random part: well-formed load, compute and query sequences with some noise.
  function automatic void build_random();
    int items;
    int n;
    int cfg_val;
    int k;
    int gap_hi;
    items = 25;
    n = 1;

    // Fill the edge table to capacity on three nodes, then overflow it.
    push_marker(K_CFG, 3);
    n = 3;
    push_beat(apsp_pkg::OP_CLEAR, 0, 0, 0, 0);
    for (int i = 0; i < EDGE_SLOTS; i++)
      push_beat(apsp_pkg::OP_ADD, $urandom_range(1, 3), $urandom_range(1, 3),
                $urandom_range(0, 900), (i % 200 < 100) ? 0 : $urandom_range(0, 18));
    push_beat(apsp_pkg::OP_ADD, 2, 3, 1, 0, 1, apsp_pkg::ST_FULL, 0);
    push_beat(apsp_pkg::OP_COMPUTE, 0, 0, 0, 1);
    for (int s = 1; s <= 3; s++)
      for (int t = 1; t <= 3; t++)
        push_beat(apsp_pkg::OP_QUERY, s, t, 0, $urandom_range(0, 3));
    push_beat(apsp_pkg::OP_CLEAR, 0, 0, 0, 0);
    items += EDGE_SLOTS + 12;

    while (items < ITEM_TARGET) begin
      gap_hi = ($urandom_range(0, 3) == 0) ? 0 : 18;
      if ($urandom_range(0, 5) == 0) begin
        case ($urandom_range(0, 9))
          0: cfg_val = 0;
          1: cfg_val = $urandom_range(65, 127);
          2: cfg_val = 64;
          3: cfg_val = 1;
          default: cfg_val = $urandom_range(2, 8);
        endcase
        push_marker(K_CFG, cfg_val);
        n = (cfg_val == 0) ? 1 : (cfg_val > 64 ? 64 : cfg_val);
      end
      if ($urandom_range(0, 6) != 0) begin
        push_beat(apsp_pkg::OP_CLEAR, 0, 0, 0, $urandom_range(0, gap_hi));
        items++;
      end
      k = (n == 64) ? $urandom_range(0, 6) : $urandom_range(0, 12);
      for (int i = 0; i < k; i++) begin
        push_beat(apsp_pkg::OP_ADD, $urandom_range(1, n), $urandom_range(1, n), pick_weight(),
                  $urandom_range(0, gap_hi));
        items++;
      end
      if ($urandom_range(0, 7) != 0) begin
        push_beat(apsp_pkg::OP_COMPUTE, 0, 0, 0, $urandom_range(0, gap_hi));
        items++;
      end
      k = $urandom_range(3, 15);
      for (int i = 0; i < k; i++) begin
        if ($urandom_range(0, 9) == 0)
          push_beat(2'($urandom_range(0, 3)), $urandom_range(0, 127), $urandom_range(0, 127),
                    $urandom_range(0, 65535), $urandom_range(0, gap_hi));
        else
          push_beat(apsp_pkg::OP_QUERY, $urandom_range(1, n), $urandom_range(1, n), 0,
                    $urandom_range(0, gap_hi));
        items++;
      end
      if ($urandom_range(0, 9) == 0) push_marker(K_PAUSE, 0);
    end
  endfunction

  // Stimulus: reset, then walk the stimulus list one beat at a time.
  initial begin
    stim_t x;
    path_result_t r;
    bit hold;
    sh_edges = 0;
    sh_nodes = NODES_MAX;
    sh_valid = 0;
    sh_neg = 0;
    build_directed();
    build_random();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < stim_q.size(); i++) begin
      x = stim_q[i];
      case (x.kind)
        K_BEAT: begin
          repeat (x.gap) @(posedge clk);
          start <= 1'b1;
          opcode <= x.op;
          source_node <= x.src;
          target_node <= x.dst;
          edge_weight_in <= x.weight;
          do @(posedge clk); while (busy);
          r = predict_path(x.op, x.src, x.dst, x.weight);
          if (x.fixed) begin
            r.st = x.fixed_status;
            r.path_len = x.fixed_dist;
          end
          pending_paths = {pending_paths, r};
          hold = (i + 1 < stim_q.size()) && stim_q[i + 1].kind == K_BEAT &&
                 stim_q[i + 1].gap == 0;
          if (!hold) start <= 1'b0;
        end
        K_CFG: begin
          while (pending_paths.size() != 0 || busy) @(posedge clk);
          node_count_wr <= 1'b1;
          node_count <= x.src;
          @(posedge clk);
          node_count_wr <= 1'b0;
          shadow_set_nodes(x.src);
        end
        default: begin
          while (pending_paths.size() != 0) @(posedge clk);
        end
      endcase
    end
    while (pending_paths.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Result checker: every done beat is matched against the oldest expectation.
  always @(posedge clk) begin
    path_result_t want;
    if (!rst && done) begin
      if (pending_paths.size() == 0) begin
        $display("%0t: unexpected result distance %0d status %0d", $time, distance, status);
        fail_count++;
      end else begin
        want = pending_paths.pop_front();
        if (distance !== want.path_len) begin
          $display("%0t: distance expected %0d actual %0d", $time, want.path_len, distance);
          fail_count++;
        end
        if (status !== want.st) begin
          $display("%0t: status expected %0d actual %0d", $time, want.st, status);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: a long stretch with no beat accepted and no result ends the run.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

endmodule
`default_nettype wire
